// File: hdl/smsps_pkg.sv
// Shared types and constants for the six-motor step phase sequencer.
// Used by six_motor_step_phase_sequencer; depends on nothing else.
package smsps_pkg;

    // Field widths of the item formats
    localparam int FUNC_W   = 2;
    localparam int INDEX_W  = 3;
    localparam int SPEED_W  = 8;
    localparam int STEP_W   = 15;
    localparam int LINE_W   = 6;
    localparam int PHASE_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Default motor count and its legal range
    localparam int MOTOR_COUNT_DEF = 6;
    localparam int MOTOR_COUNT_MAX = 16;

    // Threshold values after reset
    localparam logic [SPEED_W-1:0] SLOW_THR_RST   = 8'd1;
    localparam logic [SPEED_W-1:0] MEDIUM_THR_RST = 8'd2;
    localparam logic [SPEED_W-1:0] FAST_THR_RST   = 8'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_THR   = 2'd2;

    // Phase position inside each group of four phases
    localparam logic [1:0] PH_DIR_PUT  = 2'd0;
    localparam logic [1:0] PH_DIR_DROP = 2'd1;
    localparam logic [1:0] PH_MOVE     = 2'd2;
    localparam logic [1:0] PH_MOVE_DROP = 2'd3;

    // Slot selected by the upper phase bits during a move phase
    localparam logic [1:0] SLOT_MEDIUM = 2'd0;
    localparam logic [1:0] SLOT_FAST_A = 2'd1;
    localparam logic [1:0] SLOT_SLOW   = 2'd2;
    localparam logic [1:0] SLOT_FAST_B = 2'd3;

    // Command codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK = 2'd0,
        FUNC_LOAD = 2'd1,
        FUNC_STOP = 2'd2
    } func_t;

    // Input item
    typedef struct packed {
        func_t               func;
        logic [INDEX_W-1:0]  motor_index;
        logic [SPEED_W-1:0]  speed_value;
        logic                direction;
        logic [STEP_W-1:0]   step_count;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic [LINE_W-1:0]   motor_lines;
        logic                dir_strobe;
        logic                move_strobe;
        logic [PHASE_W-1:0]  phase;
    } out_item_t;

endpackage

// File: hdl/six_motor_step_phase_sequencer.sv
// Top level of the six-motor step phase sequencer: command decode, motor
// state, phase counter and result register. Depends on smsps_pkg.
//
// Usage:
//   The s_ channel takes command items (tick, load one motor, full stop) with
//   valid/ready; the m_ channel returns one status item per command: motor
//   line levels, both strobe levels and the phase after that command.
//   Thresholds for the slow, medium and fast slots are written through the
//   cfg_ port (index 0, 1, 2) while no command is in flight.
//   The result of a command is registered and appears on m_ in the cycle after
//   it is accepted. Throughput: one command per cycle while m_ready is high; all
//   motors are compared and decremented in parallel during a move-phase tick, and
//   the state registers plus the result register bound the path.
//   Stall: the result register holds while m_ready is low, and s_ready drops
//   until the pending result is taken.
//   Reset (aresetn low at a clock edge): thresholds return to 1, 2 and 4;
//   phase, speeds, directions, step counts, lines and strobes clear to zero;
//   no result is pending.
module six_motor_step_phase_sequencer #(
    parameter int MOTOR_COUNT = smsps_pkg::MOTOR_COUNT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration write port
    input  logic                                   cfg_wr_en,
    input  logic [smsps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [smsps_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    // command items
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  smsps_pkg::in_item_t                    s_data,
    // result items
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output smsps_pkg::out_item_t                   m_data
);

    localparam int SPEED_W = smsps_pkg::SPEED_W;
    localparam int STEP_W  = smsps_pkg::STEP_W;
    localparam int LINE_W  = smsps_pkg::LINE_W;
    localparam int PHASE_W = smsps_pkg::PHASE_W;
    // motors that own a line bit
    localparam int LANES = (MOTOR_COUNT < LINE_W) ? MOTOR_COUNT : LINE_W;

    // Thresholds
    logic [SPEED_W-1:0] slow_thr_reg;
    logic [SPEED_W-1:0] medium_thr_reg;
    logic [SPEED_W-1:0] fast_thr_reg;

    // Motor and sequencer state
    logic [PHASE_W-1:0] phase_reg,      phase_next;
    logic [SPEED_W-1:0] speed_reg       [MOTOR_COUNT];
    logic [SPEED_W-1:0] speed_next      [MOTOR_COUNT];
    logic               dir_reg         [MOTOR_COUNT];
    logic               dir_next        [MOTOR_COUNT];
    logic [STEP_W-1:0]  steps_reg       [MOTOR_COUNT];
    logic [STEP_W-1:0]  steps_next      [MOTOR_COUNT];
    logic [LINE_W-1:0]  lines_reg,      lines_next;
    logic               dir_strobe_reg, dir_strobe_next;
    logic               move_strobe_reg, move_strobe_next;

    // Result register
    logic                 m_valid_reg;
    smsps_pkg::out_item_t m_data_reg;

    logic               s_fire;
    logic [SPEED_W-1:0] slot_thr;
    logic               steps_any;

    assign s_fire  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Select the threshold of the current move slot
    always_comb begin
        unique case (phase_reg[PHASE_W-1:2])
            smsps_pkg::SLOT_MEDIUM: slot_thr = medium_thr_reg;
            smsps_pkg::SLOT_SLOW:   slot_thr = slow_thr_reg;
            smsps_pkg::SLOT_FAST_A,
            smsps_pkg::SLOT_FAST_B: slot_thr = fast_thr_reg;
            default:                slot_thr = fast_thr_reg;
        endcase
    end

    // Next state for one accepted command
    always_comb begin
        phase_next       = phase_reg;
        lines_next       = lines_reg;
        dir_strobe_next  = dir_strobe_reg;
        move_strobe_next = move_strobe_reg;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            speed_next[m] = speed_reg[m];
            dir_next[m]   = dir_reg[m];
            steps_next[m] = steps_reg[m];
        end

        unique case (s_data.func)
            smsps_pkg::FUNC_TICK: begin
                unique case (phase_reg[1:0])
                    smsps_pkg::PH_DIR_PUT: begin
                        // put direction bits on the bus
                        lines_next = '0;
                        for (int m = 0; m < LANES; m++) begin
                            lines_next[m] = dir_reg[m];
                        end
                        dir_strobe_next = 1'b1;
                    end
                    smsps_pkg::PH_MOVE: begin
                        // step each motor fast enough with steps left
                        lines_next = '0;
                        for (int m = 0; m < MOTOR_COUNT; m++) begin
                            if (speed_reg[m] >= slot_thr && steps_reg[m] != '0) begin
                                steps_next[m] = steps_reg[m] - STEP_W'(1);
                                if (m < LANES) begin
                                    lines_next[m % LINE_W] = 1'b1;
                                end
                            end
                        end
                        move_strobe_next = 1'b1;
                    end
                    smsps_pkg::PH_DIR_DROP:  dir_strobe_next  = 1'b0;
                    smsps_pkg::PH_MOVE_DROP: move_strobe_next = 1'b0;
                    default:                 move_strobe_next = 1'b0;
                endcase
                phase_next = phase_reg + PHASE_W'(1);
            end
            smsps_pkg::FUNC_LOAD: begin
                // store one motor's command; out-of-range index is dropped
                for (int m = 0; m < MOTOR_COUNT; m++) begin
                    if (int'(s_data.motor_index) == m) begin
                        speed_next[m] = s_data.speed_value;
                        dir_next[m]   = s_data.direction;
                        steps_next[m] = s_data.step_count;
                    end
                end
            end
            smsps_pkg::FUNC_STOP: begin
                // clear speeds and counts, drop both strobes
                for (int m = 0; m < MOTOR_COUNT; m++) begin
                    speed_next[m] = '0;
                    steps_next[m] = '0;
                end
                dir_strobe_next  = 1'b0;
                move_strobe_next = 1'b0;
            end
            default: begin
                // unused code: report state unchanged
                phase_next = phase_reg;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_thr_reg   <= smsps_pkg::SLOW_THR_RST;
            medium_thr_reg <= smsps_pkg::MEDIUM_THR_RST;
            fast_thr_reg   <= smsps_pkg::FAST_THR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                smsps_pkg::CFG_SLOW_THR:   slow_thr_reg   <= cfg_wdata;
                smsps_pkg::CFG_MEDIUM_THR: medium_thr_reg <= cfg_wdata;
                smsps_pkg::CFG_FAST_THR:   fast_thr_reg   <= cfg_wdata;
                default:                   slow_thr_reg   <= slow_thr_reg;
            endcase
        end
    end

    // Advance state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= '0;
            lines_reg       <= '0;
            dir_strobe_reg  <= 1'b0;
            move_strobe_reg <= 1'b0;
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                speed_reg[m] <= '0;
                dir_reg[m]   <= 1'b0;
                steps_reg[m] <= '0;
            end
        end else if (s_fire) begin
            phase_reg       <= phase_next;
            lines_reg       <= lines_next;
            dir_strobe_reg  <= dir_strobe_next;
            move_strobe_reg <= move_strobe_next;
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                speed_reg[m] <= speed_next[m];
                dir_reg[m]   <= dir_next[m];
                steps_reg[m] <= steps_next[m];
            end
        end
    end

    // Result register: load on accept, hold while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg.motor_lines <= lines_next;
            m_data_reg.dir_strobe  <= dir_strobe_next;
            m_data_reg.move_strobe <= move_strobe_next;
            m_data_reg.phase       <= phase_next;
        end
    end

    // Any step count left, for checking a stop
    always_comb begin
        steps_any = 1'b0;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            steps_any = steps_any | (steps_reg[m] != '0);
        end
    end

    // A tick advances the phase by one
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.func == smsps_pkg::FUNC_TICK
        |=> phase_reg == $past(phase_reg) + PHASE_W'(1))
        else $error("tick did not advance the phase");

    // Load and stop leave the phase alone
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.func != smsps_pkg::FUNC_TICK |=> $stable(phase_reg))
        else $error("non-tick command moved the phase");

    // A pending result reports the current phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.phase == phase_reg)
        else $error("result phase out of step with state");

    // The two strobes are never high together
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(dir_strobe_reg && move_strobe_reg))
        else $error("both strobes high");

    // A stop leaves no steps pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_data.func == smsps_pkg::FUNC_STOP |=> !steps_any)
        else $error("steps left after stop");

endmodule

// File: verif/six_motor_step_phase_sequencer_tb.sv
// Self-checking testbench for six_motor_step_phase_sequencer: directed and random
// command items, threshold sweeps and output back-pressure, all checked against an
// in-bench predictor of the motor state. Depends on smsps_pkg and the block itself.
`timescale 1ns / 1ps

module six_motor_step_phase_sequencer_tb;

    localparam int FUNC_W     = smsps_pkg::FUNC_W;
    localparam int INDEX_W    = smsps_pkg::INDEX_W;
    localparam int SPEED_W    = smsps_pkg::SPEED_W;
    localparam int STEP_W     = smsps_pkg::STEP_W;
    localparam int LINE_W     = smsps_pkg::LINE_W;
    localparam int PHASE_W    = smsps_pkg::PHASE_W;
    localparam int CFG_IDX_W  = smsps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = smsps_pkg::CFG_DATA_W;

    localparam int MOTORS      = smsps_pkg::MOTOR_COUNT_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;

    // Codes the package leaves unnamed
    localparam logic [FUNC_W-1:0]    FUNC_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    smsps_pkg::in_item_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    smsps_pkg::out_item_t m_data;

    // Predicted block state
    logic [PHASE_W-1:0] model_phase;
    logic [SPEED_W-1:0] model_speed [MOTORS];
    logic               model_dir   [MOTORS];
    logic [STEP_W-1:0]  model_steps [MOTORS];
    logic [LINE_W-1:0]  model_lines;
    logic               model_dir_stb;
    logic               model_move_stb;
    logic [SPEED_W-1:0] thr_slow, thr_medium, thr_fast;

    smsps_pkg::out_item_t pending_status [$];
    smsps_pkg::out_item_t status_want;

    int  cmds_sent;
    int  cmds_effective;
    int  statuses_checked;
    int  mismatches;
    int  settings_run;
    int  stall_cycles;
    bit  steady;
    int  hold_requests;
    int  hold_served;
    int  hold_left;

    six_motor_step_phase_sequencer #(
        .MOTOR_COUNT(MOTORS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #5 aclk = ~aclk;

    // Clear predicted state to its reset values
    task automatic reset_model();
        model_phase    = '0;
        model_lines    = '0;
        model_dir_stb  = 1'b0;
        model_move_stb = 1'b0;
        thr_slow       = smsps_pkg::SLOW_THR_RST;
        thr_medium     = smsps_pkg::MEDIUM_THR_RST;
        thr_fast       = smsps_pkg::FAST_THR_RST;
        for (int m = 0; m < MOTORS; m++) begin
            model_speed[m] = '0;
            model_dir[m]   = 1'b0;
            model_steps[m] = '0;
        end
    endtask

    // Apply one command to the predicted state and return the status it reports
    function automatic smsps_pkg::out_item_t apply_command(smsps_pkg::in_item_t cmd);
        logic [SPEED_W-1:0] thr;
        smsps_pkg::out_item_t st;
        case (cmd.func)
            smsps_pkg::FUNC_TICK: begin
                case (model_phase[1:0])
                    smsps_pkg::PH_DIR_PUT: begin
                        model_lines = '0;
                        for (int m = 0; m < MOTORS; m++)
                            if (m < LINE_W && model_dir[m]) model_lines[m] = 1'b1;
                        model_dir_stb = 1'b1;
                    end
                    smsps_pkg::PH_MOVE: begin
                        case (model_phase[3:2])
                            smsps_pkg::SLOT_MEDIUM: thr = thr_medium;
                            smsps_pkg::SLOT_SLOW:   thr = thr_slow;
                            default:                thr = thr_fast;
                        endcase
                        model_lines = '0;
                        for (int m = 0; m < MOTORS; m++) begin
                            if (model_speed[m] >= thr && model_steps[m] != 0) begin
                                if (m < LINE_W) model_lines[m] = 1'b1;
                                model_steps[m] = model_steps[m] - 1'b1;
                            end
                        end
                        model_move_stb = 1'b1;
                    end
                    smsps_pkg::PH_DIR_DROP: model_dir_stb = 1'b0;
                    default:                model_move_stb = 1'b0;
                endcase
                model_phase = model_phase + 1'b1;
            end
            smsps_pkg::FUNC_LOAD: begin
                if (cmd.motor_index < MOTORS) begin
                    model_speed[cmd.motor_index] = cmd.speed_value;
                    model_dir[cmd.motor_index]   = cmd.direction;
                    model_steps[cmd.motor_index] = cmd.step_count;
                end
            end
            smsps_pkg::FUNC_STOP: begin
                for (int m = 0; m < MOTORS; m++) begin
                    model_speed[m] = '0;
                    model_steps[m] = '0;
                end
                model_dir_stb  = 1'b0;
                model_move_stb = 1'b0;
            end
            default: ;
        endcase
        st.motor_lines = model_lines;
        st.dir_strobe  = model_dir_stb;
        st.move_strobe = model_move_stb;
        st.phase       = model_phase;
        return st;
    endfunction

    // Offer one item with a random gap, hold it until accepted, log the expected status
    task automatic send_cmd(input smsps_pkg::in_item_t cmd);
        while (!steady && $urandom_range(99) < 30) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= cmd;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_status.push_back(apply_command(cmd));
        cmds_sent++;
        if (!((cmd.func == smsps_pkg::FUNC_LOAD && cmd.motor_index >= MOTORS) ||
              cmd.func == FUNC_SPARE))
            cmds_effective++;
        @(negedge aclk);
    endtask

    function automatic smsps_pkg::in_item_t load_cmd(logic [INDEX_W-1:0] idx,
                                                     logic [SPEED_W-1:0] spd,
                                                     logic dir, logic [STEP_W-1:0] steps);
        smsps_pkg::in_item_t c;
        c.func        = smsps_pkg::FUNC_LOAD;
        c.motor_index = idx;
        c.speed_value = spd;
        c.direction   = dir;
        c.step_count  = steps;
        return c;
    endfunction

    // Non-load commands carry random filler in the unused fields
    function automatic smsps_pkg::in_item_t plain_cmd(logic [FUNC_W-1:0] code);
        smsps_pkg::in_item_t c;
        logic [31:0] raw;
        raw = $urandom;
        c = raw[$bits(smsps_pkg::in_item_t)-1:0];
        c.func = smsps_pkg::func_t'(code);
        return c;
    endfunction

    // Speeds cluster near the thresholds, with the full range mixed in
    function automatic logic [SPEED_W-1:0] rand_speed();
        if ($urandom_range(99) < 60) return SPEED_W'($urandom_range(0, 8));
        return SPEED_W'($urandom_range(0, 255));
    endfunction

    // Mostly short moves so motors run out of steps inside a program
    function automatic logic [STEP_W-1:0] rand_steps();
        int r;
        r = $urandom_range(99);
        if (r < 70) return STEP_W'($urandom_range(0, 12));
        if (r < 90) return STEP_W'($urandom_range(0, 32767));
        case ($urandom_range(2))
            0:       return '0;
            1:       return STEP_W'(1);
            default: return '1;
        endcase
    endfunction

    // One motion program: loads followed by a run of ticks, or noise / a stop
    task automatic one_program();
        int r;
        int n;
        logic [31:0] raw;
        r = $urandom_range(99);
        if (r < 10) begin
            n = $urandom_range(1, 4);
            repeat (n) begin
                raw = $urandom;
                send_cmd(raw[$bits(smsps_pkg::in_item_t)-1:0]);
            end
        end else if (r < 16) begin
            send_cmd(plain_cmd(smsps_pkg::FUNC_STOP));
        end else begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_cmd(load_cmd(INDEX_W'($urandom_range(0, MOTORS - 1)), rand_speed(),
                                  1'($urandom_range(1)), rand_steps()));
            n = $urandom_range(8, 48);
            repeat (n) send_cmd(plain_cmd(smsps_pkg::FUNC_TICK));
        end
    endtask

    task automatic run_programs(input int n_items);
        int start;
        start = cmds_effective;
        while (cmds_effective - start < n_items) one_program();
    endtask

    // Drop valid and wait until every status has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_threshold(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
        case (idx)
            smsps_pkg::CFG_SLOW_THR:   thr_slow   = val;
            smsps_pkg::CFG_MEDIUM_THR: thr_medium = val;
            smsps_pkg::CFG_FAST_THR:   thr_fast   = val;
            default: ;
        endcase
    endtask

    // Extremes, ignored loads, the spare code, exhaustion and a full phase cycle
    task automatic test_directed();
        send_cmd(load_cmd(3'd0, 8'd255, 1'b1, '1));
        send_cmd(load_cmd(3'd5, 8'd0, 1'b0, '0));
        send_cmd(load_cmd(3'd1, smsps_pkg::MEDIUM_THR_RST, 1'b1, STEP_W'(1)));
        send_cmd(load_cmd(3'd2, smsps_pkg::SLOW_THR_RST, 1'b0, STEP_W'(2)));
        send_cmd(load_cmd(3'd6, 8'd255, 1'b1, '1));
        send_cmd(load_cmd(3'd7, 8'd255, 1'b1, '1));
        send_cmd(plain_cmd(FUNC_SPARE));
        repeat (16) send_cmd(plain_cmd(smsps_pkg::FUNC_TICK));
        send_cmd(plain_cmd(smsps_pkg::FUNC_STOP));
        wait_idle();
    endtask

    // Several threshold settings, the extremes among them, then back to reset values
    task automatic test_threshold_sweep();
        logic [CFG_DATA_W-1:0] sl, md, fs;
        for (int s = 0; s < 6; s++) begin
            case (s)
                0: begin sl = 8'd0;   md = 8'd0;   fs = 8'd0;   end
                1: begin sl = 8'd255; md = 8'd255; fs = 8'd255; end
                2: begin sl = 8'd0;   md = 8'd255; fs = 8'd128; end
                5: begin
                    sl = smsps_pkg::SLOW_THR_RST;
                    md = smsps_pkg::MEDIUM_THR_RST;
                    fs = smsps_pkg::FAST_THR_RST;
                end
                default: begin
                    sl = CFG_DATA_W'($urandom_range(0, 8));
                    md = CFG_DATA_W'($urandom_range(0, 8));
                    fs = CFG_DATA_W'($urandom_range(0, 255));
                end
            endcase
            if (s == 3) write_threshold(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 255)));
            write_threshold(smsps_pkg::CFG_SLOW_THR, sl);
            write_threshold(smsps_pkg::CFG_MEDIUM_THR, md);
            write_threshold(smsps_pkg::CFG_FAST_THR, fs);
            settings_run++;
            run_programs(180);
            wait_idle();
        end
    endtask

    // Random programs with idling on both sides
    task automatic test_random_programs();
        run_programs(400);
        wait_idle();
    endtask

    // Back-to-back items with both sides always ready
    task automatic test_streaming();
        steady = 1'b1;
        run_programs(120);
        wait_idle();
        steady = 1'b0;
    endtask

    // Hold the result side off while the sender keeps offering items
    task automatic test_backpressure();
        hold_requests++;
        steady = 1'b1;
        run_programs(40);
        steady = 1'b0;
        wait_idle();
    endtask

    // Result side: random stalls, a steady stretch, and the requested hold-off
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 30);
        end
    end

    // Compare each status item with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $error("status item %h arrived with nothing expected", m_data);
                mismatches++;
            end else begin
                status_want = pending_status.pop_front();
                statuses_checked++;
                if (m_data.motor_lines !== status_want.motor_lines) begin
                    $error("motor_lines: expected %h, got %h",
                           status_want.motor_lines, m_data.motor_lines);
                    mismatches++;
                end
                if (m_data.dir_strobe !== status_want.dir_strobe) begin
                    $error("dir_strobe: expected %b, got %b",
                           status_want.dir_strobe, m_data.dir_strobe);
                    mismatches++;
                end
                if (m_data.move_strobe !== status_want.move_strobe) begin
                    $error("move_strobe: expected %b, got %b",
                           status_want.move_strobe, m_data.move_strobe);
                    mismatches++;
                end
                if (m_data.phase !== status_want.phase) begin
                    $error("phase: expected %0d, got %0d", status_want.phase, m_data.phase);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("six_motor_step_phase_sequencer test failed");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_threshold_sweep();
        test_random_programs();
        test_streaming();
        test_backpressure();

        $display("Sent %0d command items (%0d acting on the block), checked %0d status items,",
                 cmds_sent, cmds_effective, statuses_checked);
        $display("across %0d threshold settings, idle gaps, a steady stretch and a long stall.",
                 settings_run);
        if (mismatches == 0) begin
            $display("six_motor_step_phase_sequencer test passed");
        end else begin
            $display("six_motor_step_phase_sequencer test failed");
        end
        $finish;
    end

endmodule
